// File: design/assert_macros.svh
// Assertion macros shared by the dot engine modules.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// File: design/mmd_pkg.sv
// Shared types and constants of the matrix multiply dot engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mmd_pkg;

   // Field widths
   localparam int SIZE_W = 7;
   localparam int IDX_W  = 6;
   localparam int VAL_W  = 16;
   localparam int PROD_W = 2 * VAL_W;
   localparam int DOT_W  = 38;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // Register indexes of the csr port
   localparam logic [1:0] REG_ROWS  = 2'd0;
   localparam logic [1:0] REG_COLS  = 2'd1;
   localparam logic [1:0] REG_INNER = 2'd2;

   // Request commands
   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_DOT    = 2'd2;

   // Job kinds handed from front to back
   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_DOT    = 2'd2;
   localparam logic [1:0] OP_BAD    = 2'd3;

   // Job queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
      logic [SIZE_W-1:0] inner;
   } sizes_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
   } job_type;

endpackage

// File: design/mmd_front.sv
// Front end of the dot engine: accepts request beats and classifies them.
// Depends on mmd_pkg and assert_macros.svh; feeds jobs into mmd_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmd_front
   import mmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sizes_type         sizes,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_cmd,
   input  logic [IDX_W-1:0]  in_row,
   input  logic [IDX_W-1:0]  in_col,
   input  logic [VAL_W-1:0]  in_value,
   input  logic              queue_full,
   output logic              push_valid,
   output job_type           push_job
);

   logic row_lt_m;
   logic row_lt_k;
   logic col_lt_n;
   logic col_lt_k;
   logic keep;
   logic [1:0] op;

   // Range checks against the sizes in use
   assign row_lt_m = {1'b0, in_row} < sizes.rows;
   assign row_lt_k = {1'b0, in_row} < sizes.inner;
   assign col_lt_n = {1'b0, in_col} < sizes.cols;
   assign col_lt_k = {1'b0, in_col} < sizes.inner;

   // Classify: drop out-of-range loads and unused commands, and mark out-of-range computes as index errors
   always_comb begin
      keep = 1'b0;
      op   = OP_BAD;
      unique case (in_cmd)
         CMD_LOAD_A: begin
            keep = row_lt_m && col_lt_k;
            op   = OP_LOAD_A;
         end
         CMD_LOAD_B: begin
            keep = row_lt_k && col_lt_n;
            op   = OP_LOAD_B;
         end
         CMD_DOT: begin
            keep = 1'b1;
            op   = (row_lt_m && col_lt_n) ? OP_DOT : OP_BAD;
         end
         default: begin
            keep = 1'b0;
            op   = OP_BAD;
         end
      endcase
   end

   assign in_ready       = !queue_full;
   assign push_valid     = in_valid && !queue_full && keep && !reset;
   assign push_job.op    = op;
   assign push_job.row   = in_row;
   assign push_job.col   = in_col;
   assign push_job.value = in_value;

   `ASSERT_NEVER(a_front_no_push_full, push_valid && queue_full,
      "front pushed a job into a full queue")

endmodule

// File: design/mmd_queue.sv
// Short job queue between the front and back ends of the dot engine.
// Depends on mmd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmd_queue
   import mmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    full,
   output logic    pop_valid,
   output job_type pop_job,
   input  logic    pop_ready
);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QPTR_W:0]    count_ff;
   logic [QPTR_W:0]    count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold job payloads
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_CLK(a_queue_count_bound, count_ff <= (QPTR_W+1)'(QUEUE_DEPTH),
      "queue occupancy above depth")
   `ASSERT_CLK(a_queue_ptr_gap, wr_ptr_ff == QPTR_W'(rd_ptr_ff + count_ff[QPTR_W-1:0]),
      "queue pointers disagree with occupancy")

endmodule

// File: design/mmd_back.sv
// Back end of the dot engine: matrix stores, multiply-accumulate and result register.
// Depends on mmd_pkg and assert_macros.svh; pops jobs from mmd_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmd_back
   import mmd_pkg::*;
#(
   parameter int MAX_DIM = 64
)(
   input  logic              clock,
   input  logic              reset,
   input  logic [SIZE_W-1:0] inner_size,
   input  logic              job_valid,
   input  job_type           job,
   output logic              job_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [IDX_W-1:0]  out_row,
   output logic [IDX_W-1:0]  out_col,
   output logic [DOT_W-1:0]  out_dot,
   output logic              out_err
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [VAL_W-1:0]         mem_a [DEPTH];
   logic [VAL_W-1:0]         mem_b [DEPTH];

   logic [1:0]               state_ff;
   logic [1:0]               state_in;
   logic [SIZE_W-1:0]        cnt_ff;
   logic [SIZE_W-1:0]        cnt_in;
   logic [IDX_W-1:0]         row_ff;
   logic [IDX_W-1:0]         row_in;
   logic [IDX_W-1:0]         col_ff;
   logic [IDX_W-1:0]         col_in;
   logic                     rd_vld_ff;
   logic                     rd_vld_in;
   logic                     prod_vld_ff;
   logic                     prod_vld_in;
   logic signed [VAL_W-1:0]  a_rd_ff;
   logic signed [VAL_W-1:0]  b_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [DOT_W-1:0]         acc_ff;
   logic [DOT_W-1:0]         acc_in;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic [IDX_W-1:0]         out_row_ff;
   logic [IDX_W-1:0]         out_row_in;
   logic [IDX_W-1:0]         out_col_ff;
   logic [IDX_W-1:0]         out_col_in;
   logic [DOT_W-1:0]         out_dot_ff;
   logic [DOT_W-1:0]         out_dot_in;
   logic                     out_err_ff;
   logic                     out_err_in;

   logic                     out_free;
   logic                     take;
   logic                     issue;
   logic                     we_a;
   logic                     we_b;
   logic [AW-1:0]            waddr;
   logic [AW-1:0]            raddr_a;
   logic [AW-1:0]            raddr_b;

   assign out_free  = !out_valid_ff || out_ready;
   assign job_ready = (state_ff == ST_IDLE) && (job.op != OP_BAD || out_free);
   assign take      = job_valid && job_ready;
   assign we_a      = take && (job.op == OP_LOAD_A);
   assign we_b      = take && (job.op == OP_LOAD_B);
   assign issue     = (state_ff == ST_RUN) && (cnt_ff < inner_size);

   // Store addresses, row-major with a stride of MAX_DIM
   assign waddr   = AW'(int'(job.row) * MAX_DIM + int'(job.col));
   assign raddr_a = AW'(int'(row_ff) * MAX_DIM + int'(cnt_ff));
   assign raddr_b = AW'(int'(cnt_ff) * MAX_DIM + int'(col_ff));

   // Matrix stores: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[waddr] <= job.value;
      end
      a_rd_ff <= mem_a[raddr_a];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[waddr] <= job.value;
      end
      b_rd_ff <= mem_b[raddr_b];
   end

   // Sequencer, multiply stage and accumulator
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rd_vld_in    = issue;
      prod_vld_in  = rd_vld_ff;
      prod_in      = a_rd_ff * b_rd_ff;
      acc_in       = acc_ff;
      out_valid_in = out_ready ? 1'b0 : out_valid_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_dot_in   = out_dot_ff;
      out_err_in   = out_err_ff;

      if (prod_vld_ff) begin
         acc_in = acc_ff + {{(DOT_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take && job.op == OP_DOT) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               row_in   = job.row;
               col_in   = job.col;
               acc_in   = '0;
            end else if (take && job.op == OP_BAD) begin
               out_valid_in = 1'b1;
               out_row_in   = job.row;
               out_col_in   = job.col;
               out_dot_in   = '0;
               out_err_in   = 1'b1;
            end
         end
         ST_RUN: begin
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               out_valid_in = 1'b1;
               out_row_in   = row_ff;
               out_col_in   = col_ff;
               out_dot_in   = acc_ff;
               out_err_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold datapath payload
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
      out_dot_ff <= out_dot_in;
      out_err_ff <= out_err_in;
   end

   assign out_valid = out_valid_ff;
   assign out_row   = out_row_ff;
   assign out_col   = out_col_ff;
   assign out_dot   = out_dot_ff;
   assign out_err   = out_err_ff;

   `ASSERT_CLK(a_back_idle_drained, (state_ff == ST_IDLE) |-> (!rd_vld_ff && !prod_vld_ff),
      "multiply pipeline busy while sequencer idle")
   `ASSERT_CLK(a_back_cnt_bound, (state_ff == ST_RUN) |-> (cnt_ff <= inner_size),
      "inner counter ran past the inner size")
   `ASSERT_CLK(a_back_err_zero, (out_valid_ff && out_err_ff) |-> (out_dot_ff == '0),
      "index error result carries a nonzero value")

endmodule

// File: design/matrix_multiply_dot_engine.sv
// Matrix multiply dot engine: m x k matrix A and k x n matrix B in local stores;
// each compute request returns one exact Q22.16 entry of A*B.
//
// Usage:
//   req channel: tuser = command (load A, load B, compute); tdata carries the
//   row index, column index and Q8.8 element value. Loads outside the sizes in
//   use and the unused command are dropped without a result.
//   rsp channel: one beat per compute request, in request order, with the echoed
//   row and column, the exact dot value and in tuser an index error flag (set,
//   with value zero, when the entry lies outside the sizes in use).
//   csr port: rows, columns and inner size; write only while the engine is idle.
// Throughput:
//   A compute runs one multiply-accumulate per cycle, bounded by the single
//   read port of each store. Loads and index-error computes are handled as they
//   leave the job queue. A four-entry job queue decouples request intake from
//   the back end.
// Reset: synchronous; empties the queue and result register and sets all sizes
// to 64. Store contents are undefined until written.
// Stall: the result beat holds until taken; loads keep draining meanwhile, and
// req_tready drops once the job queue is full.
`timescale 1ns / 1ps

module matrix_multiply_dot_engine
   import mmd_pkg::*;
#(
   parameter int MAX_DIM = 64
)(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [5:0] row_index, [11:6] col_index, [27:12] elem_value
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [5:0] out_row, [11:6] out_col, [49:12] dot_value
   output logic        rsp_tuser,   // [0] index_error
   // Configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam logic [8:0] MAX_DIM_W = 9'(MAX_DIM);

   logic [SIZE_W-1:0] rows_ff;
   logic [SIZE_W-1:0] rows_in;
   logic [SIZE_W-1:0] cols_ff;
   logic [SIZE_W-1:0] cols_in;
   logic [SIZE_W-1:0] inner_ff;
   logic [SIZE_W-1:0] inner_in;
   sizes_type         sizes;

   logic              queue_full;
   logic              push_valid;
   job_type           push_job;
   logic              pop_valid;
   job_type           pop_job;
   logic              pop_ready;

   logic [IDX_W-1:0]  out_row;
   logic [IDX_W-1:0]  out_col;
   logic [DOT_W-1:0]  out_dot;

   // Size registers
   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      inner_in = inner_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ROWS:  rows_in  = csr_wdata;
            REG_COLS:  cols_in  = csr_wdata;
            REG_INNER: inner_in = csr_wdata;
            default:   rows_in  = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= SIZE_RESET;
         cols_ff  <= SIZE_RESET;
         inner_ff <= SIZE_RESET;
      end else begin
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         inner_ff <= inner_in;
      end
   end

   // Clamp sizes to the store dimension
   assign sizes.rows  = ({2'b00, rows_ff} > MAX_DIM_W)  ? MAX_DIM_W[SIZE_W-1:0] : rows_ff;
   assign sizes.cols  = ({2'b00, cols_ff} > MAX_DIM_W)  ? MAX_DIM_W[SIZE_W-1:0] : cols_ff;
   assign sizes.inner = ({2'b00, inner_ff} > MAX_DIM_W) ? MAX_DIM_W[SIZE_W-1:0] : inner_ff;

   mmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .sizes      (sizes),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_row     (req_tdata[5:0]),
      .in_col     (req_tdata[11:6]),
      .in_value   (req_tdata[27:12]),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   mmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   mmd_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .inner_size (sizes.inner),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_ready  (pop_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_row    (out_row),
      .out_col    (out_col),
      .out_dot    (out_dot),
      .out_err    (rsp_tuser)
   );

   assign rsp_tdata = {6'b000000, out_dot, out_col, out_row};

endmodule

// File: sim/tb.sv
// Testbench for matrix_multiply_dot_engine: drives load and compute beats under
// several size settings and checks every result beat against an in-bench predictor.
// Depends on mmd_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb
   import mmd_pkg::*;
();

   localparam int CLOCK_PERIOD  = 4;
   localparam int MAX_DIM       = 64;
   localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ITEM_TARGET   = 1650;
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int REPORT_LIMIT  = 10;

   // Command code the engine must drop
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [DOT_W-1:0] dot;
      logic             err;
   } dot_entry_type;

   // Predicts result beats from accepted request beats and checks them in order
   class dot_predictor;
      logic [VAL_W-1:0] a_store [STORE_DEPTH];
      logic [VAL_W-1:0] b_store [STORE_DEPTH];
      bit               a_filled [STORE_DEPTH];
      bit               b_filled [STORE_DEPTH];
      int               rows_sz;
      int               cols_sz;
      int               inner_sz;
      dot_entry_type    pending_dots [$];
      int               failures;
      int               results_checked;
      int               index_errors;
      int               dot_requests;
      int               items_applied;

      function new();
         rows_sz         = MAX_DIM;
         cols_sz         = MAX_DIM;
         inner_sz        = MAX_DIM;
         failures        = 0;
         results_checked = 0;
         index_errors    = 0;
         dot_requests    = 0;
         items_applied   = 0;
      endfunction

      // Sizes above the store dimension saturate
      function void set_size(logic [1:0] idx, logic [SIZE_W-1:0] raw);
         int sz;
         sz = (int'(raw) > MAX_DIM) ? MAX_DIM : int'(raw);
         case (idx)
            REG_ROWS:  rows_sz  = sz;
            REG_COLS:  cols_sz  = sz;
            REG_INNER: inner_sz = sz;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_dots.size();
      endfunction

      // First inner index whose A or B entry was never written, or -1
      function int first_gap(int row, int col, output bit in_b);
         int i;
         in_b = 1'b0;
         for (i = 0; i < inner_sz; i++) begin
            if (!a_filled[row * MAX_DIM + i]) return i;
            if (!b_filled[i * MAX_DIM + col]) begin
               in_b = 1'b1;
               return i;
            end
         end
         return -1;
      endfunction

      function void note_request(logic [1:0] cmd, logic [IDX_W-1:0] row,
                                 logic [IDX_W-1:0] col, logic [VAL_W-1:0] value);
         int            i;
         int            addr;
         longint        sum;
         dot_entry_type entry;
         addr = int'(row) * MAX_DIM + int'(col);
         case (cmd)
            CMD_LOAD_A: begin
               if (int'(row) < rows_sz && int'(col) < inner_sz) begin
                  a_store[addr]  = value;
                  a_filled[addr] = 1'b1;
                  items_applied++;
               end
            end
            CMD_LOAD_B: begin
               if (int'(row) < inner_sz && int'(col) < cols_sz) begin
                  b_store[addr]  = value;
                  b_filled[addr] = 1'b1;
                  items_applied++;
               end
            end
            CMD_DOT: begin
               entry.row = row;
               entry.col = col;
               entry.dot = '0;
               entry.err = 1'b0;
               if (int'(row) >= rows_sz || int'(col) >= cols_sz) begin
                  entry.err = 1'b1;
               end else begin
                  // Exact sum; at 64 inner terms it stays well inside 38 bits
                  sum = 0;
                  for (i = 0; i < inner_sz; i++)
                     sum += longint'($signed(a_store[int'(row) * MAX_DIM + i])) *
                            longint'($signed(b_store[i * MAX_DIM + int'(col)]));
                  entry.dot = sum[DOT_W-1:0];
               end
               pending_dots.push_back(entry);
               dot_requests++;
               items_applied++;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                 logic [DOT_W-1:0] dot, logic err);
         dot_entry_type want;
         results_checked++;
         if (err) index_errors++;
         if (pending_dots.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result beat: row %0d col %0d dot %h err %b",
                        row, col, dot, err);
            return;
         end
         want = pending_dots.pop_front();
         if (want.row !== row || want.col !== col || want.dot !== dot || want.err !== err) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"mismatch: expected row %0d col %0d dot %h err %b,",
                         " got row %0d col %0d dot %h err %b"},
                        want.row, want.col, want.dot, want.err, row, col, dot, err);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [5:0] row_index, [11:6] col_index, [27:12] elem_value
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // [5:0] out_row, [11:6] out_col, [49:12] dot_value
   logic        rsp_tuser;   // [0] index_error
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [6:0]  csr_wdata;

   dot_predictor dots;
   int           cycle_count = 0;
   int           size_settings = 0;
   int           items_sent = 0;
   bit           tgt_valid = 1'b0;
   int           tgt_row;
   int           tgt_col;

   matrix_multiply_dot_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[matrix_multiply_dot_engine] ERROR");
         $finish;
      end
   end

   // No idling on either side during calm stretches, one block of cycles in every four
   function automatic bit calm_stretch();
      return (cycle_count / 2048) % 4 == 1;
   endfunction

   // Stall the result side now and then
   always @(negedge clock) begin
      rsp_tready <= calm_stretch() || ($urandom_range(0, 99) >= 8);
   end

   // Check each result beat as it is taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         dots.check_result(rsp_tdata[5:0], rsp_tdata[11:6], rsp_tdata[49:12], rsp_tuser);
   end

   function automatic logic [IDX_W-1:0] pick_index(int limit);
      if (limit == 0 || $urandom_range(0, 7) == 0) return IDX_W'($urandom_range(0, MAX_DIM - 1));
      return IDX_W'($urandom_range(0, limit - 1));
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         4:       return 16'h0100;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Entered and left just after a falling edge; holds the beat until taken
   task automatic send_request(input logic [1:0] cmd, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
      while (!calm_stretch() && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, value, col, row};
      do @(posedge clock); while (!req_tready);
      dots.note_request(cmd, row, col, value);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait for the engine to drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (dots.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_sizes(input logic [6:0] rows, input logic [6:0] cols,
                              input logic [6:0] inner);
      csr_we    <= 1'b1;
      csr_index <= REG_ROWS;
      csr_wdata <= rows;
      dots.set_size(REG_ROWS, rows);
      @(negedge clock);
      csr_index <= REG_COLS;
      csr_wdata <= cols;
      dots.set_size(REG_COLS, cols);
      @(negedge clock);
      csr_index <= REG_INNER;
      csr_wdata <= inner;
      dots.set_size(REG_INNER, inner);
      @(negedge clock);
      csr_we <= 1'b0;
      size_settings++;
   endtask

   // Mostly loads and computes on a target entry whose operands are complete;
   // missing operands of the target are loaded first, so no unwritten entry is read
   task automatic pick_request(output logic [1:0] cmd, output logic [IDX_W-1:0] row,
                               output logic [IDX_W-1:0] col, output logic [VAL_W-1:0] value);
      int roll;
      int gap;
      bit gap_in_b;
      roll  = $urandom_range(0, 99);
      value = pick_value();
      row   = IDX_W'($urandom_range(0, MAX_DIM - 1));
      col   = IDX_W'($urandom_range(0, MAX_DIM - 1));
      if (roll < 30) begin
         cmd = CMD_LOAD_A;
         row = pick_index(dots.rows_sz);
         col = pick_index(dots.inner_sz);
      end else if (roll < 60) begin
         cmd = CMD_LOAD_B;
         row = pick_index(dots.inner_sz);
         col = pick_index(dots.cols_sz);
      end else if (roll < 96) begin
         cmd = CMD_DOT;
         if (dots.rows_sz == 0 || dots.cols_sz == 0 ||
             (roll < 66 && (dots.rows_sz < MAX_DIM || dots.cols_sz < MAX_DIM))) begin
            // Push the entry outside the sizes in use
            if (int'(row) < dots.rows_sz && int'(col) < dots.cols_sz) begin
               if (dots.rows_sz < MAX_DIM)
                  row = IDX_W'($urandom_range(dots.rows_sz, MAX_DIM - 1));
               else
                  col = IDX_W'($urandom_range(dots.cols_sz, MAX_DIM - 1));
            end
         end else begin
            if (!tgt_valid || tgt_row >= dots.rows_sz || tgt_col >= dots.cols_sz) begin
               tgt_row   = $urandom_range(0, dots.rows_sz - 1);
               tgt_col   = $urandom_range(0, dots.cols_sz - 1);
               tgt_valid = 1'b1;
            end
            gap = dots.first_gap(tgt_row, tgt_col, gap_in_b);
            if (gap < 0) begin
               row       = IDX_W'(tgt_row);
               col       = IDX_W'(tgt_col);
               tgt_valid = ($urandom_range(0, 3) == 0);
            end else if (gap_in_b) begin
               cmd = CMD_LOAD_B;
               row = IDX_W'(gap);
               col = IDX_W'(tgt_col);
            end else begin
               cmd = CMD_LOAD_A;
               row = IDX_W'(tgt_row);
               col = IDX_W'(gap);
            end
         end
      end else begin
         cmd = CMD_UNUSED;
      end
   endtask

   task automatic run_phase(input logic [6:0] rows, input logic [6:0] cols,
                            input logic [6:0] inner);
      logic [1:0]       cmd;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
      int               n;
      settle();
      write_sizes(rows, cols, inner);
      tgt_valid = 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
         pick_request(cmd, row, col, value);
         send_request(cmd, row, col, value);
      end
   endtask

   function automatic logic [6:0] pick_size();
      if ($urandom_range(0, 9) == 0) return 7'd64;
      return 7'($urandom_range(1, 8));
   endfunction

   initial begin
      dots       = new();
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: 2x2x2 with extreme products, ignored loads, unused command,
      // out-of-range computes and an overwrite
      write_sizes(7'd2, 7'd2, 7'd2);
      send_request(CMD_LOAD_A, 6'd0, 6'd0, 16'h8000);
      send_request(CMD_LOAD_A, 6'd0, 6'd1, 16'h8000);
      send_request(CMD_LOAD_B, 6'd0, 6'd0, 16'h8000);
      send_request(CMD_LOAD_B, 6'd1, 6'd0, 16'h8000);
      send_request(CMD_DOT,    6'd0, 6'd0, 16'h0000);
      send_request(CMD_LOAD_A, 6'd1, 6'd0, 16'h7FFF);
      send_request(CMD_LOAD_A, 6'd1, 6'd1, 16'h7FFF);
      send_request(CMD_LOAD_B, 6'd0, 6'd1, 16'h8000);
      send_request(CMD_LOAD_B, 6'd1, 6'd1, 16'h7FFF);
      send_request(CMD_DOT,    6'd1, 6'd1, 16'hFFFF);
      send_request(CMD_DOT,    6'd0, 6'd1, 16'h0000);
      send_request(CMD_DOT,    6'd1, 6'd0, 16'h0000);
      send_request(CMD_LOAD_A, 6'd63, 6'd63, 16'hFFFF);
      send_request(CMD_LOAD_B, 6'd2, 6'd0, 16'h1234);
      send_request(CMD_UNUSED, 6'd63, 6'd63, 16'hFFFF);
      send_request(CMD_DOT,    6'd63, 6'd63, 16'hFFFF);
      send_request(CMD_DOT,    6'd2, 6'd0, 16'h0000);
      send_request(CMD_DOT,    6'd0, 6'd2, 16'h0000);
      send_request(CMD_LOAD_A, 6'd0, 6'd0, 16'h0100);
      send_request(CMD_DOT,    6'd0, 6'd0, 16'h0000);

      // Fixed settings: smallest, largest, saturating, zero in each register
      run_phase(7'd1, 7'd1, 7'd1);
      run_phase(7'd64, 7'd64, 7'd64);
      run_phase(7'd8, 7'd8, 7'd8);
      run_phase(7'd127, 7'd65, 7'd100);
      run_phase(7'd0, 7'd4, 7'd4);
      run_phase(7'd4, 7'd0, 7'd4);
      run_phase(7'd4, 7'd4, 7'd0);
      run_phase(7'd3, 7'd7, 7'd5);
      while (items_sent < ITEM_TARGET)
         run_phase(pick_size(), pick_size(), pick_size());

      settle();
      $display("sent %0d request beats (%0d applied) over %0d size settings",
               items_sent, dots.items_applied, size_settings);
      $display("checked %0d result beats (%0d index errors), %0d failures",
               dots.results_checked, dots.index_errors, dots.failures);
      if (dots.failures == 0 && dots.pending() == 0)
         $display("[matrix_multiply_dot_engine] OK");
      else
         $display("[matrix_multiply_dot_engine] ERROR");
      $finish;
   end

endmodule

// File: matrix_multiply_dot_engine.f
+incdir+design
design/mmd_pkg.sv
design/mmd_front.sv
design/mmd_queue.sv
design/mmd_back.sv
design/matrix_multiply_dot_engine.sv
sim/tb.sv
